@@ hw/rtl/hsv_to_rgb_converter_defines.svh @@
// assertion macros for the hsv to rgb converter checker
`ifndef HSV_TO_RGB_CONVERTER_DEFINES_SVH
`define HSV_TO_RGB_CONVERTER_DEFINES_SVH

// property checked only outside reset
`define HSV2RGB_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// property checked on every edge, reset included
`define HSV2RGB_ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ hw/rtl/hsv2rgb_pkg.sv @@
// types, constants and fixed-point helpers for the hsv to rgb converter
package hsv2rgb_pkg;

   localparam int FRAC_BITS = 12;
   localparam int FX_W      = FRAC_BITS + 1;
   localparam int H6_W      = FRAC_BITS + 3;
   localparam int SECT_W    = 3;

   localparam logic [FX_W-1:0] ONE_FX = FX_W'(1) << FRAC_BITS;

   localparam logic [SECT_W-1:0] SECT_0 = SECT_W'(0);
   localparam logic [SECT_W-1:0] SECT_1 = SECT_W'(1);
   localparam logic [SECT_W-1:0] SECT_2 = SECT_W'(2);
   localparam logic [SECT_W-1:0] SECT_3 = SECT_W'(3);
   localparam logic [SECT_W-1:0] SECT_4 = SECT_W'(4);

   typedef struct packed {
      logic [FX_W-1:0] hue;
      logic [FX_W-1:0] saturation;
      logic [FX_W-1:0] brightness;
   } hsv2rgb_req_type;

   typedef struct packed {
      logic [FX_W-1:0] red;
      logic [FX_W-1:0] green;
      logic [FX_W-1:0] blue;
   } hsv2rgb_rsp_type;

   typedef struct packed {
      logic [FX_W-1:0] v;
      logic [FX_W-1:0] p;
      logic [FX_W-1:0] q;
      logic [FX_W-1:0] t;
   } hsv2rgb_pqtv_type;

   function automatic logic [FX_W-1:0] sat_one(input logic [FX_W-1:0] x);
      return (x > ONE_FX) ? ONE_FX : x;
   endfunction

   // truncated fixed-point product, operands within 0..one
   function automatic logic [FX_W-1:0] fx_mul(input logic [FX_W-1:0] a,
                                              input logic [FX_W-1:0] b);
      logic [2*FX_W-1:0] prod;
      prod = {{FX_W{1'b0}}, a} * {{FX_W{1'b0}}, b};
      return prod[FRAC_BITS +: FX_W];
   endfunction

endpackage

@@ hw/rtl/hsv_to_rgb_converter.sv @@
// an accepted req word passes the s1, s2 and s3 registers and the output register before rsp_valid
// throughput: one color per cycle while rsp_stall does not hold the four-stage multiply pipeline
// each stage holds its word under rsp_stall and empty stages still fill
// reset clears the stage valid bits only; data registers are not reset
// top level of the hsv to rgb converter
module hsv_to_rgb_converter
   import hsv2rgb_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   output logic            req_stall,
   input  hsv2rgb_req_type req_word,
   output logic            rsp_valid,
   input  logic            rsp_stall,
   output hsv2rgb_rsp_type rsp_word
);

   // stage 1: saturated inputs, sector and fraction
   logic              s1_valid_ff, s1_valid_in;
   logic [SECT_W-1:0] s1_sector_ff;
   logic [FRAC_BITS-1:0] s1_f_ff;
   logic [FX_W-1:0]   s1_s_ff, s1_v_ff;

   // stage 2: s*f, s*(1-f), p
   logic              s2_valid_ff, s2_valid_in;
   logic [SECT_W-1:0] s2_sector_ff;
   logic [FX_W-1:0]   s2_sf_ff, s2_sg_ff, s2_p_ff, s2_v_ff;

   // stage 3: v, p, q, t
   logic              s3_valid_ff, s3_valid_in;
   logic [SECT_W-1:0] s3_sector_ff;
   hsv2rgb_pqtv_type  s3_pqtv_ff;

   // stage 4: output word
   logic              rsp_valid_ff, rsp_valid_in;
   hsv2rgb_rsp_type   rsp_word_ff, color;

   logic              out_rdy, s3_rdy, s2_rdy, s1_rdy;
   logic [FX_W-1:0]   h_sat, s_sat, v_sat;
   logic [H6_W-1:0]   h6;
   logic [FX_W-1:0]   f_ext;

   assign out_rdy = !rsp_valid_ff || !rsp_stall;
   assign s3_rdy  = !s3_valid_ff || out_rdy;
   assign s2_rdy  = !s2_valid_ff || s3_rdy;
   assign s1_rdy  = !s1_valid_ff || s2_rdy;

   assign req_stall = !s1_rdy;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_word_ff;

   assign h_sat = sat_one(req_word.hue);
   assign s_sat = sat_one(req_word.saturation);
   assign v_sat = sat_one(req_word.brightness);

   // hue times six as 4h + 2h
   assign h6 = {h_sat, 2'b00} + {1'b0, h_sat, 1'b0};

   assign f_ext = {1'b0, s1_f_ff};

   assign s1_valid_in  = s1_rdy ? req_valid   : s1_valid_ff;
   assign s2_valid_in  = s2_rdy ? s1_valid_ff : s2_valid_ff;
   assign s3_valid_in  = s3_rdy ? s2_valid_ff : s3_valid_ff;
   assign rsp_valid_in = out_rdy ? s3_valid_ff : rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         s3_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         s2_valid_ff  <= s2_valid_in;
         s3_valid_ff  <= s3_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_rdy) begin
         s1_sector_ff <= h6[FRAC_BITS +: SECT_W];
         s1_f_ff      <= h6[FRAC_BITS-1:0];
         s1_s_ff      <= s_sat;
         s1_v_ff      <= v_sat;
      end
      if (s2_rdy) begin
         s2_sector_ff <= s1_sector_ff;
         s2_sf_ff     <= fx_mul(s1_s_ff, f_ext);
         s2_sg_ff     <= fx_mul(s1_s_ff, ONE_FX - f_ext);
         s2_p_ff      <= fx_mul(s1_v_ff, ONE_FX - s1_s_ff);
         s2_v_ff      <= s1_v_ff;
      end
      if (s3_rdy) begin
         s3_sector_ff <= s2_sector_ff;
         s3_pqtv_ff.v <= s2_v_ff;
         s3_pqtv_ff.p <= s2_p_ff;
         s3_pqtv_ff.q <= fx_mul(s2_v_ff, ONE_FX - s2_sf_ff);
         s3_pqtv_ff.t <= fx_mul(s2_v_ff, ONE_FX - s2_sg_ff);
      end
      if (out_rdy) begin
         rsp_word_ff <= color;
      end
   end

   // zero saturation needs no special path: p, q and t all equal v
   hsv2rgb_sel u_sel (
      .pqtv   (s3_pqtv_ff),
      .sector (s3_sector_ff),
      .color  (color)
   );

endmodule

@@ hw/rtl/hsv2rgb_sel.sv @@
// sector select: routes v, p, q and t onto red, green and blue
module hsv2rgb_sel
   import hsv2rgb_pkg::*;
(
   input  hsv2rgb_pqtv_type    pqtv,
   input  logic [SECT_W-1:0]   sector,
   output hsv2rgb_rsp_type     color
);

   always_comb begin
      case (sector)
         SECT_0: begin
            color = '{red: pqtv.v, green: pqtv.t, blue: pqtv.p};
         end
         SECT_1: begin
            color = '{red: pqtv.q, green: pqtv.v, blue: pqtv.p};
         end
         SECT_2: begin
            color = '{red: pqtv.p, green: pqtv.v, blue: pqtv.t};
         end
         SECT_3: begin
            color = '{red: pqtv.p, green: pqtv.q, blue: pqtv.v};
         end
         SECT_4: begin
            color = '{red: pqtv.t, green: pqtv.p, blue: pqtv.v};
         end
         // sector five, and hue of exactly one
         default: begin
            color = '{red: pqtv.v, green: pqtv.p, blue: pqtv.q};
         end
      endcase
   end

endmodule

@@ hw/rtl/hsv2rgb_checker.sv @@
// port-level checker for the hsv to rgb converter, bound to the top level
`include "hsv_to_rgb_converter_defines.svh"

module hsv2rgb_checker
   import hsv2rgb_pkg::*;
(
   input logic            clock,
   input logic            reset,
   input logic            req_valid,
   input logic            req_stall,
   input hsv2rgb_req_type req_word,
   input logic            rsp_valid,
   input logic            rsp_stall,
   input hsv2rgb_rsp_type rsp_word
);

   `HSV2RGB_ASSERT_ALWAYS(a_reset_empty, clock, reset |=> !rsp_valid, "rsp_valid after reset")

   `HSV2RGB_ASSERT(a_req_hold, clock, reset, req_valid && req_stall |=> req_valid && $stable(req_word), "stalled req word changed")

   `HSV2RGB_ASSERT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_word), "stalled rsp word changed")

   `HSV2RGB_ASSERT(a_stall_from_out, clock, reset, req_stall |-> rsp_valid && rsp_stall, "req stalled while output could move")

   `HSV2RGB_ASSERT(a_rsp_range, clock, reset, rsp_valid |-> rsp_word.red <= ONE_FX && rsp_word.green <= ONE_FX && rsp_word.blue <= ONE_FX, "rsp color above one")

endmodule

bind hsv_to_rgb_converter hsv2rgb_checker u_hsv2rgb_checker (.*);

@@ verif/hsv_to_rgb_converter_tb.sv @@
// testbench for the hsv to rgb converter: directed and random colors checked against a predictor
`timescale 1ns / 1ps

module hsv_to_rgb_converter_tb;
   import hsv2rgb_pkg::*;

   localparam int CYCLE_LIMIT   = 400000;
   localparam int HOLD_CYCLES   = 60;
   localparam int PHASE_WORDS   = 215;
   localparam int DRAIN_CYCLES  = 8;
   localparam int PRINT_LIMIT   = 30;

   class color_scoreboard;
      hsv2rgb_rsp_type expected_colors[$];
      int errors;

      function new();
         errors = 0;
      endfunction

      function bit [FX_W-1:0] clip_to_one(bit [FX_W-1:0] x);
         return (x > ONE_FX) ? ONE_FX : x;
      endfunction

      function bit [FX_W-1:0] scaled_product(bit [FX_W-1:0] a, bit [FX_W-1:0] b);
         bit [2*FX_W-1:0] full;
         full = a * b;
         return full[FRAC_BITS +: FX_W];
      endfunction

      function hsv2rgb_rsp_type predict_rgb(hsv2rgb_req_type w);
         bit [FX_W-1:0]   h, s, v, f, p, q, t;
         bit [H6_W-1:0]   h6;
         bit [SECT_W-1:0] sector;
         hsv2rgb_rsp_type c;
         h = clip_to_one(w.hue);
         s = clip_to_one(w.saturation);
         v = clip_to_one(w.brightness);
         if (s == '0) begin
            c.red   = v;
            c.green = v;
            c.blue  = v;
         end else begin
            h6     = h * 3'd6;
            sector = h6[H6_W-1:FRAC_BITS];
            f      = {1'b0, h6[FRAC_BITS-1:0]};
            p      = scaled_product(v, ONE_FX - s);
            q      = scaled_product(v, ONE_FX - scaled_product(s, f));
            t      = scaled_product(v, ONE_FX - scaled_product(s, ONE_FX - f));
            case (sector)
               SECT_0: c = '{red: v, green: t, blue: p};
               SECT_1: c = '{red: q, green: v, blue: p};
               SECT_2: c = '{red: p, green: v, blue: t};
               SECT_3: c = '{red: p, green: q, blue: v};
               SECT_4: c = '{red: t, green: p, blue: v};
               // hue of one lands here too and maps like the last sector
               default: c = '{red: v, green: p, blue: q};
            endcase
         end
         return c;
      endfunction

      task report(string msg);
         if (errors < PRINT_LIMIT) $display("mismatch at %0t: %s", $realtime, msg);
         errors++;
      endtask

      function void note_input(hsv2rgb_req_type w);
         expected_colors.push_back(predict_rgb(w));
      endfunction

      task check_result(hsv2rgb_rsp_type got);
         hsv2rgb_rsp_type want;
         if (expected_colors.size() == 0) begin
            report($sformatf("unexpected rsp word %h", got));
         end else begin
            want = expected_colors.pop_front();
            if (got.red !== want.red)
               report($sformatf("red got %0d want %0d", got.red, want.red));
            if (got.green !== want.green)
               report($sformatf("green got %0d want %0d", got.green, want.green));
            if (got.blue !== want.blue)
               report($sformatf("blue got %0d want %0d", got.blue, want.blue));
         end
      endtask
   endclass

   logic            clock = 1'b0;
   logic            reset = 1'b1;
   logic            req_valid = 1'b0;
   logic            req_stall;
   hsv2rgb_req_type req_word = '0;
   logic            rsp_valid;
   logic            rsp_stall = 1'b0;
   hsv2rgb_rsp_type rsp_word;

   color_scoreboard sb = new();
   int send_idle_pct = 0;
   int recv_idle_pct = 0;
   int hold_left = 0;
   logic hold_start = 1'b0;
   int cycle_count = 0;

   hsv_to_rgb_converter dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_word  (req_word),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_word  (rsp_word)
   );

   always #1 clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("CHECK FAILED");
         $finish;
      end
   end

   // receiver: check accepted words, then pick the stall for the next cycle
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) sb.check_result(rsp_word);
      if (hold_start) begin
         hold_start <= 1'b0;
         hold_left  <= HOLD_CYCLES;
         rsp_stall  <= 1'b1;
      end else if (hold_left > 0) begin
         hold_left <= hold_left - 1;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(0, 99) < recv_idle_pct);
      end
   end

   function automatic hsv2rgb_req_type make_color(int h, int s, int v);
      hsv2rgb_req_type w;
      w.hue        = FX_W'(h);
      w.saturation = FX_W'(s);
      w.brightness = FX_W'(v);
      return w;
   endfunction

   // mostly in range, with zero, one and above-one values mixed in
   function automatic logic [FX_W-1:0] rand_field();
      int pick;
      pick = $urandom_range(0, 15);
      case (pick)
         0:       return '0;
         1:       return ONE_FX;
         2:       return FX_W'($urandom_range(int'(ONE_FX) + 1, (1 << FX_W) - 1));
         default: return FX_W'($urandom_range(0, int'(ONE_FX)));
      endcase
   endfunction

   task send_word(hsv2rgb_req_type w);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_word  <= w;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      sb.note_input(w);
   endtask

   task wait_drained();
      req_valid <= 1'b0;
      @(posedge clock);
      while (sb.expected_colors.size() != 0) @(posedge clock);
   endtask

   initial begin
      hsv2rgb_req_type directed[$];
      int k;

      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      directed.push_back(make_color(0, 0, 0));
      directed.push_back(make_color(4096, 4096, 4096));
      directed.push_back(make_color(0, 4096, 4096));
      directed.push_back(make_color(4096, 2048, 3000));   // hue of one
      directed.push_back(make_color(1234, 0, 2500));      // gray
      directed.push_back(make_color(4096, 0, 4096));
      for (k = 0; k < 6; k++)
         directed.push_back(make_color(k * 4096 / 6 + 300, 3000, 3900));
      directed.push_back(make_color(682, 4096, 4096));    // sector edges
      directed.push_back(make_color(683, 4096, 4096));
      directed.push_back(make_color(4095, 4096, 4096));
      directed.push_back(make_color(2048, 4096, 0));
      directed.push_back(make_color(8191, 8191, 8191));   // above one everywhere
      directed.push_back(make_color(4097, 1000, 2000));
      directed.push_back(make_color(1500, 6000, 3000));
      directed.push_back(make_color(2500, 2000, 5000));
      directed.push_back(make_color(3500, 1, 4096));
      directed.push_back(make_color(2730, 4096, 1));
      directed.push_back(make_color(5461, 4095, 4095));
      foreach (directed[i]) send_word(directed[i]);
      wait_drained();

      for (int phase = 0; phase < 3; phase++) begin
         case (phase)
            0: begin
               send_idle_pct = 32;
               recv_idle_pct <= 47;
            end
            1: begin
               send_idle_pct = 47;
               recv_idle_pct <= 32;
            end
            default: begin
               send_idle_pct = 0;
               recv_idle_pct <= 0;
            end
         endcase
         for (int i = 0; i < PHASE_WORDS; i++) begin
            // long receiver hold-off while words keep coming
            if (i == 40) hold_start <= 1'b1;
            send_word('{hue: rand_field(), saturation: rand_field(),
                        brightness: rand_field()});
         end
         wait_drained();
      end

      repeat (DRAIN_CYCLES) @(posedge clock);
      if (sb.errors == 0 && sb.expected_colors.size() == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule
